// File: src/assert_macros.svh
// assertion macros used by the checker file gfl_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GFL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define GFL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/gfl_pkg.sv
// types, constants and keyword tables of the grammar file lexer
`timescale 1ns / 1ps
package gfl_pkg;

	localparam int NAME_SLOTS_DEF = 32;
	// holds any text length up to the largest slot count
	localparam int LEN_W = 6;
	localparam int NKW = 12;

	localparam logic [4:0] K_END    = 5'd0;
	localparam logic [4:0] K_COLON  = 5'd1;
	localparam logic [4:0] K_SEMI   = 5'd2;
	localparam logic [4:0] K_BAR    = 5'd3;
	localparam logic [4:0] K_EQUALS = 5'd4;
	localparam logic [4:0] K_IDENT  = 5'd5;
	localparam logic [4:0] K_COMMA  = 5'd6;
	localparam logic [4:0] K_OUTPUT = 5'd7;
	localparam logic [4:0] K_LPAR   = 5'd8;
	localparam logic [4:0] K_RPAR   = 5'd9;
	localparam logic [4:0] K_TERM   = 5'd10;
	localparam logic [4:0] K_LEFT   = 5'd11;
	localparam logic [4:0] K_BINARY = 5'd12;
	localparam logic [4:0] K_RIGHT  = 5'd13;
	localparam logic [4:0] K_MARK   = 5'd14;
	localparam logic [4:0] K_PREC   = 5'd15;
	localparam logic [4:0] K_LCURL  = 5'd16;
	localparam logic [4:0] K_NUMBER = 5'd21;
	localparam logic [4:0] K_RAW    = 5'd22;
	localparam logic [4:0] K_ERROR  = 5'd23;

	localparam logic [2:0] E_ANGLE   = 3'd0;
	localparam logic [2:0] E_QUOTE   = 3'd1;
	localparam logic [2:0] E_COMMENT = 3'd2;
	localparam logic [2:0] E_EOF_COM = 3'd3;
	localparam logic [2:0] E_KEYWORD = 3'd4;

	typedef enum logic [9:0] {
		M_IDLE      = 10'b0000000001,
		M_COM_OPEN  = 10'b0000000010,
		M_COM_BODY  = 10'b0000000100,
		M_COM_STAR  = 10'b0000001000,
		M_ANGLE     = 10'b0000010000,
		M_QUOTE     = 10'b0000100000,
		M_QUOTE_ESC = 10'b0001000000,
		M_DIRECTIVE = 10'b0010000000,
		M_NUMBER    = 10'b0100000000,
		M_NAME      = 10'b1000000000
	} mode_t;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_TEXT = 4'b0010,
		B_KA   = 4'b0100,
		B_KB   = 4'b1000
	} bstate_t;

	// one queued job: optional text run, first kind result, optional second result
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             bank;
		logic [4:0]       kind_a;
		logic [7:0]       char_a;
		logic [2:0]       code_a;
		logic             has_b;
		logic [4:0]       kind_b;
		logic [7:0]       char_b;
		logic [2:0]       code_b;
		logic [15:0]      line;
	} cmd_t;

	localparam logic [79:0] KW_STR [NKW] = '{
		80'("term"), 80'("token"), 80'("left"), 80'("nonassoc"), 80'("binary"),
		80'("right"), 80'("prec"), 80'("start"), 80'("type"), 80'("union"),
		80'("attributes"), 80'("attribute")
	};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd4, 4'd5, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd5, 4'd4, 4'd5, 4'd10, 4'd9
	};
	localparam logic [4:0] KW_KIND [NKW] = '{
		5'd10, 5'd10, 5'd11, 5'd12, 5'd12, 5'd13, 5'd15, 5'd17, 5'd18, 5'd19,
		5'd20, 5'd20
	};

	function automatic logic [7:0] kw_char(input int i, input logic [LEN_W-1:0] pos);
		int sh;
		logic [7:0] r;
		begin
			r = 8'h00;
			if (pos < LEN_W'(KW_LEN[i])) begin
				sh = 8 * (int'(KW_LEN[i]) - 1 - int'(pos));
				r = KW_STR[i][sh +: 8];
			end
			return r;
		end
	endfunction

	function automatic logic is_dec_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
			(c == "_") || (c == ".") || (c == "$");
	endfunction

endpackage

// File: src/gfl_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module gfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: src/gfl_front.sv
// character scanner: mode machine, text stores and job generation
`timescale 1ns / 1ps
module gfl_front #(
	parameter int NAME_SLOTS = gfl_pkg::NAME_SLOTS_DEF,
	parameter int AW = $clog2(2 * NAME_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_in,
	input  logic                end_of_input,
	input  logic                q_full,
	input  logic                txt_busy,
	output logic                push,
	output gfl_pkg::cmd_t       push_cmd,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [7:0]          wr_data
);
	import gfl_pkg::*;

	localparam logic [LEN_W-1:0] NS_L = LEN_W'(NAME_SLOTS);

	mode_t            mode_q, n_mode;
	logic [LEN_W-1:0] len_q, n_len, pos, wr_idx;
	logic             kf_q, n_kf;
	logic [7:0]       qc_q, n_qc;
	logic [15:0]      line_q, n_line;
	logic [NKW-1:0]   mask_q, n_mask;
	logic             bank_q, n_bank;
	logic             acc, has_a, do_idle, cnt_nl, st_en, st_name, st_fresh, found;
	logic [7:0]       c, st_data, fc;
	logic             eof;
	logic [4:0]       i_kind, f_kind;
	logic [7:0]       i_char;
	logic             i_has;
	cmd_t             cmd;

	assign in_ready = !q_full && !txt_busy;
	assign acc = in_valid && in_ready;
	assign c = char_in;
	assign eof = end_of_input;

	always_comb begin
		n_mode = mode_q; n_len = len_q; n_kf = kf_q; n_qc = qc_q; n_line = line_q;
		n_mask = mask_q; n_bank = bank_q;
		cmd = '0; cmd.line = line_q; cmd.bank = bank_q;
		has_a = 1'b0; do_idle = 1'b0; cnt_nl = 1'b0;
		st_en = 1'b0; st_name = 1'b0; st_fresh = 1'b0; st_data = 8'h00;
		i_has = 1'b0; i_kind = K_END; i_char = 8'h00;
		found = 1'b0; f_kind = K_IDENT; fc = 8'h00; pos = '0; wr_idx = '0;
		wr_en = 1'b0; wr_data = 8'h00;

		case (mode_q)
			M_COM_OPEN: begin
				if (eof || c != "*") begin
					has_a = 1'b1; cmd.kind_a = K_ERROR; cmd.code_a = E_COMMENT;
					n_len = '0; n_kf = 1'b0; n_mode = M_IDLE;
					cnt_nl = !eof && (c == 8'h0a);
				end else begin
					n_mode = M_COM_BODY;
				end
			end
			M_COM_BODY, M_COM_STAR: begin
				if (eof) begin
					has_a = 1'b1; cmd.kind_a = K_ERROR; cmd.code_a = E_EOF_COM;
					n_len = '0; n_kf = 1'b0; n_mode = M_IDLE;
				end else if (c == "/" && mode_q == M_COM_STAR) begin
					n_mode = M_IDLE;
				end else if (c == "*") begin
					n_mode = M_COM_STAR;
				end else begin
					cnt_nl = (c == 8'h0a);
					n_mode = M_COM_BODY;
				end
			end
			M_ANGLE: begin
				if (!eof && c == ">") begin
					n_mode = M_IDLE;
					has_a = 1'b1; cmd.kind_a = K_IDENT; cmd.len = len_q;
					n_len = '0; n_bank = !bank_q;
				end else if (eof || c == 8'h0a) begin
					has_a = 1'b1; cmd.kind_a = K_ERROR; cmd.code_a = E_ANGLE;
					n_len = '0; n_kf = 1'b0; n_mode = M_IDLE;
					cnt_nl = !eof;
				end else begin
					st_en = 1'b1; st_data = c;
				end
			end
			M_QUOTE: begin
				if (eof || c == 8'h0a) begin
					has_a = 1'b1; cmd.kind_a = K_ERROR; cmd.code_a = E_QUOTE;
					n_len = '0; n_kf = 1'b0; n_mode = M_IDLE;
					cnt_nl = !eof;
				end else if (c == "\\") begin
					st_en = 1'b1; st_data = c; n_mode = M_QUOTE_ESC;
				end else if (c == qc_q) begin
					n_mode = M_IDLE;
					has_a = 1'b1; cmd.kind_a = K_IDENT; cmd.len = len_q;
					n_len = '0; n_bank = !bank_q;
				end else begin
					st_en = 1'b1; st_data = c;
				end
			end
			M_QUOTE_ESC: begin
				if (eof) begin
					has_a = 1'b1; cmd.kind_a = K_ERROR; cmd.code_a = E_QUOTE;
					n_len = '0; n_kf = 1'b0; n_mode = M_IDLE;
				end else begin
					st_en = 1'b1; st_data = c; n_mode = M_QUOTE;
				end
			end
			M_DIRECTIVE: begin
				n_mode = M_IDLE;
				has_a = 1'b1;
				if (eof) begin
					cmd.kind_a = K_END;
				end else begin
					case (c)
						"0": cmd.kind_a = K_TERM;
						"<": cmd.kind_a = K_LEFT;
						"2": cmd.kind_a = K_BINARY;
						">": cmd.kind_a = K_RIGHT;
						"%", "\\": cmd.kind_a = K_MARK;
						"=": cmd.kind_a = K_PREC;
						"{": cmd.kind_a = K_LCURL;
						default: begin
							// keyword or fallback word start
							has_a = 1'b0;
							n_kf = 1'b1;
							n_len = '0;
							if (is_dec_digit(c)) begin
								n_kf = 1'b0; st_en = 1'b1; st_data = c; n_mode = M_NUMBER;
							end else if (is_name_char(c)) begin
								st_en = 1'b1; st_name = 1'b1; st_fresh = 1'b1; st_data = c;
								n_mode = M_NAME;
							end else begin
								n_kf = 1'b0;
								has_a = 1'b1; cmd.kind_a = K_RAW; cmd.char_a = c;
							end
						end
					endcase
				end
			end
			M_NUMBER: begin
				if (!eof && is_dec_digit(c)) begin
					st_en = 1'b1; st_data = c;
				end else begin
					n_mode = M_IDLE;
					has_a = 1'b1; cmd.kind_a = K_NUMBER; cmd.len = len_q;
					n_len = '0; n_bank = !bank_q;
					do_idle = 1'b1;
				end
			end
			M_NAME: begin
				if (!eof && (is_name_char(c) || is_dec_digit(c))) begin
					st_en = 1'b1; st_name = 1'b1; st_data = c;
				end else begin
					n_mode = M_IDLE;
					do_idle = 1'b1;
					has_a = 1'b1;
					if (!kf_q) begin
						cmd.kind_a = K_IDENT; cmd.len = len_q;
						n_len = '0; n_bank = !bank_q;
					end else begin
						n_kf = 1'b0;
						for (int i = NKW - 1; i >= 0; i--) begin
							if (mask_q[i] && LEN_W'(KW_LEN[i]) == len_q) begin
								found = 1'b1; f_kind = KW_KIND[i];
							end
						end
						if (found) begin
							cmd.kind_a = f_kind; cmd.len = len_q;
							n_len = '0; n_bank = !bank_q;
						end else begin
							cmd.kind_a = K_ERROR; cmd.code_a = E_KEYWORD;
							n_len = '0;
						end
					end
				end
			end
			default: begin
				n_mode = M_IDLE;
				do_idle = 1'b1;
			end
		endcase

		// idle scan, also the rescan of a terminating character
		if (do_idle) begin
			if (eof) begin
				i_has = 1'b1; i_kind = K_END;
			end else if (c <= 8'h20) begin
				cnt_nl = (c == 8'h0a);
			end else begin
				case (c)
					"/": n_mode = M_COM_OPEN;
					":": begin i_has = 1'b1; i_kind = K_COLON; end
					";": begin i_has = 1'b1; i_kind = K_SEMI; end
					"|": begin i_has = 1'b1; i_kind = K_BAR; end
					"{", "=": begin i_has = 1'b1; i_kind = K_EQUALS; end
					",": begin i_has = 1'b1; i_kind = K_COMMA; end
					"^": begin i_has = 1'b1; i_kind = K_OUTPUT; end
					"(": begin i_has = 1'b1; i_kind = K_LPAR; end
					")": begin i_has = 1'b1; i_kind = K_RPAR; end
					"<": begin n_len = '0; n_mode = M_ANGLE; end
					"\"", "'": begin
						n_qc = c; n_len = '0;
						st_en = 1'b1; st_data = " ";
						n_mode = M_QUOTE;
					end
					"%", "\\": n_mode = M_DIRECTIVE;
					default: begin
						n_kf = 1'b0;
						n_len = '0;
						if (is_dec_digit(c)) begin
							st_en = 1'b1; st_data = c; n_mode = M_NUMBER;
						end else if (is_name_char(c)) begin
							st_en = 1'b1; st_name = 1'b1; st_fresh = 1'b1; st_data = c;
							n_mode = M_NAME;
						end else begin
							n_mode = M_IDLE;
							i_has = 1'b1; i_kind = K_RAW; i_char = c;
						end
					end
				endcase
			end
			if (i_has) begin
				if (has_a) begin
					cmd.has_b = 1'b1; cmd.kind_b = i_kind; cmd.char_b = i_char;
				end else begin
					has_a = 1'b1; cmd.kind_a = i_kind; cmd.char_a = i_char;
				end
			end
		end

		if (st_en) begin
			pos = n_len;
			fc = st_data;
			if (st_name) begin
				if (n_kf && st_data >= "A" && st_data <= "Z") begin
					fc = st_data + 8'd32;
				end
				for (int i = 0; i < NKW; i++) begin
					n_mask[i] = (st_fresh || mask_q[i]) && (kw_char(i, pos) == fc);
				end
			end
			wr_en = acc;
			wr_data = fc;
			if (n_len < NS_L) begin
				wr_idx = n_len;
				n_len = n_len + LEN_W'(1);
			end else begin
				wr_idx = NS_L - LEN_W'(1);
			end
		end

		if (cnt_nl && line_q != 16'hffff) begin
			n_line = line_q + 16'd1;
		end
	end

	assign wr_addr = n_bank ? AW'(NAME_SLOTS) + AW'(wr_idx) : AW'(wr_idx);
	assign push = acc && has_a;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q  <= '0;
			kf_q   <= 1'b0;
			qc_q   <= 8'h00;
			line_q <= 16'd1;
			mask_q <= '0;
			bank_q <= 1'b0;
		end else if (acc) begin
			mode_q <= n_mode;
			len_q  <= n_len;
			kf_q   <= n_kf;
			qc_q   <= n_qc;
			line_q <= n_line;
			mask_q <= n_mask;
			bank_q <= n_bank;
		end
	end
endmodule

// File: src/gfl_cmdq.sv
// two entry job queue between scanner and emitter
`timescale 1ns / 1ps
module gfl_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gfl_pkg::cmd_t push_cmd,
	input  logic          pop,
	output gfl_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import gfl_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign head  = ent_q[rp_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: src/gfl_back.sv
// result emitter: drains buffered text then the kind results
`timescale 1ns / 1ps
module gfl_back #(
	parameter int NAME_SLOTS = gfl_pkg::NAME_SLOTS_DEF,
	parameter int AW = $clog2(2 * NAME_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  gfl_pkg::cmd_t       head,
	output logic                pop,
	output logic [AW-1:0]       rd_addr,
	input  logic [7:0]          rd_data,
	output logic                txt_done,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [4:0]          token_kind,
	output logic                is_text,
	output logic [7:0]          text_char,
	output logic [2:0]          error_code,
	output logic [15:0]         line_number,
	output logic                last
);
	import gfl_pkg::*;

	bstate_t          st_q;
	cmd_t             cur_q;
	logic [LEN_W-1:0] idx_q;
	logic             dok_q;
	logic             slot_free, load_txt, load_any;

	assign slot_free = !out_valid || out_ready;
	assign pop = (st_q == B_IDLE) && !q_empty;
	assign rd_addr = cur_q.bank ? AW'(NAME_SLOTS) + AW'(idx_q) : AW'(idx_q);
	assign load_txt = (st_q == B_TEXT) && dok_q && slot_free;
	assign txt_done = load_txt && (idx_q + LEN_W'(1) == cur_q.len);
	assign load_any = load_txt || (((st_q == B_KA) || (st_q == B_KB)) && slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			out_valid <= 1'b0;
			idx_q     <= '0;
			dok_q     <= 1'b0;
		end else begin
			out_valid <= load_any || (out_valid && !out_ready);
			// read data is good in the cycle after the address settles
			dok_q <= !(pop || load_txt);
			case (st_q)
				B_IDLE: begin
					if (!q_empty) begin
						idx_q <= '0;
						st_q  <= (head.len != '0) ? B_TEXT : B_KA;
					end
				end
				B_TEXT: begin
					if (load_txt) begin
						idx_q <= idx_q + LEN_W'(1);
						if (txt_done) st_q <= B_KA;
					end
				end
				B_KA: begin
					if (slot_free) begin
						st_q <= cur_q.has_b ? B_KB : B_IDLE;
					end
				end
				B_KB: begin
					if (slot_free) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load_txt) begin
			token_kind <= cur_q.kind_a; is_text <= 1'b1; text_char <= rd_data;
			error_code <= '0; line_number <= cur_q.line; last <= 1'b0;
		end else if (st_q == B_KA && slot_free) begin
			token_kind <= cur_q.kind_a; is_text <= 1'b0; text_char <= cur_q.char_a;
			error_code <= cur_q.code_a; line_number <= cur_q.line; last <= 1'b1;
		end else if (st_q == B_KB && slot_free) begin
			token_kind <= cur_q.kind_b; is_text <= 1'b0; text_char <= cur_q.char_b;
			error_code <= cur_q.code_b; line_number <= cur_q.line; last <= 1'b1;
		end
	end
endmodule

// File: src/grammar_file_lexer.sv
// Grammar file lexer, top level.
// Input channel: one source byte per transaction (char_in, end_of_input) on
// in_valid / in_ready. Output channel: one result per transaction on
// out_valid / out_ready; token text leaves one character per result
// (is_text = 1) ahead of the kind result, which carries last = 1.
// A scanner front end classifies each byte as it is accepted and queues a job
// in a two entry queue when the byte yields results; the emitter drains the
// job's text from a two bank text ram one character at a time, then emits the
// kind results. While a token's text is still being drained, in_ready stays
// low, so the byte after one that closes a token with text waits until that
// text has been drained. A closing byte's job passes through the queue entry
// and the emitter's job register to the output register; text characters
// also wait for the registered ram read.
// Reset clears the scan mode, text length and flags and sets the line
// count to one; the text ram is not cleared and needs no clearing pass.
// A stalled receiver holds the output register and backs up into the queue
// and then into in_ready.
`timescale 1ns / 1ps
module grammar_file_lexer #(
	parameter int NAME_SLOTS = gfl_pkg::NAME_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic        is_text,
	output logic [7:0]  text_char,
	output logic [2:0]  error_code,
	output logic [15:0] line_number,
	output logic        last
);
	import gfl_pkg::*;

	localparam int AW = $clog2(2 * NAME_SLOTS);

	cmd_t          push_cmd, head;
	logic          push, pop, q_full, q_empty, wr_en, txt_done;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;
	logic [1:0]    txt_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_pend_q <= 2'd0;
		end else begin
			txt_pend_q <= txt_pend_q + 2'(push && push_cmd.len != '0) - 2'(txt_done);
		end
	end

	gfl_front #(.NAME_SLOTS(NAME_SLOTS), .AW(AW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.char_in(char_in), .end_of_input(end_of_input), .q_full(q_full),
		.txt_busy(txt_pend_q != 2'd0), .push(push), .push_cmd(push_cmd),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	gfl_cmdq u_cmdq (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
		.head(head), .full(q_full), .empty(q_empty)
	);

	gfl_ram #(.WIDTH(8), .DEPTH(2 * NAME_SLOTS)) u_text_ram (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	gfl_back #(.NAME_SLOTS(NAME_SLOTS), .AW(AW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .head(head), .pop(pop),
		.rd_addr(rd_addr), .rd_data(rd_data), .txt_done(txt_done),
		.out_valid(out_valid), .out_ready(out_ready), .token_kind(token_kind),
		.is_text(is_text), .text_char(text_char), .error_code(error_code),
		.line_number(line_number), .last(last)
	);
endmodule

// File: src/gfl_checker.sv
// port level checks for the grammar file lexer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gfl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  token_kind,
	input logic        is_text,
	input logic [2:0]  error_code,
	input logic        last
);
	import gfl_pkg::*;

	`GFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`GFL_ASSERT_NOW(a_text_not_last, out_valid && is_text, !last)
	`GFL_ASSERT_NOW(a_kind_last, out_valid && !is_text, last)
	`GFL_ASSERT_NOW(a_code_only_err, out_valid && token_kind != K_ERROR, error_code == E_ANGLE)
endmodule

bind grammar_file_lexer gfl_checker u_gfl_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.token_kind(token_kind), .is_text(is_text), .error_code(error_code), .last(last)
);

// File: sim/grammar_file_lexer_tb.sv
// testbench of the grammar file lexer: byte stream in, token results checked
`timescale 1ns / 1ps
module grammar_file_lexer_tb;
	import gfl_pkg::*;

	localparam int SLOTS = NAME_SLOTS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum int {
		S_IDLE, S_COM_OPEN, S_COM_BODY, S_COM_STAR, S_ANGLE, S_QUOTE,
		S_QUOTE_ESC, S_DIRECTIVE, S_NUMBER, S_NAME
	} scan_t;

	typedef struct {
		logic [4:0]  kind;
		logic        txt;
		logic [7:0]  ch;
		logic [2:0]  code;
		logic [15:0] line;
		logic        lst;
	} token_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_in = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  token_kind;
	logic        is_text;
	logic [7:0]  text_char;
	logic [2:0]  error_code;
	logic [15:0] line_number;
	logic        last;

	grammar_file_lexer i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.char_in(char_in), .end_of_input(end_of_input), .out_valid(out_valid),
		.out_ready(out_ready), .token_kind(token_kind), .is_text(is_text),
		.text_char(text_char), .error_code(error_code), .line_number(line_number),
		.last(last)
	);

	always #1 clk = ~clk;

	// lexer state mirror
	scan_t       lx_mode;
	logic [7:0]  lx_buf [SLOTS];
	int          lx_len;
	logic        lx_kw;
	logic [7:0]  lx_quote;
	logic [15:0] lx_line;

	token_res_t  expected_tokens[$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	function automatic logic digit_c(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic name_c(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" ||
			c == "." || c == "$";
	endfunction

	function automatic void bump_line();
		if (lx_line != 16'hffff)
			lx_line++;
	endfunction

	function automatic void push_tok(logic [4:0] k, logic t, logic [7:0] c,
			logic [2:0] e, logic l);
		token_res_t r;
		r.kind = k; r.txt = t; r.ch = c; r.code = e; r.line = lx_line; r.lst = l;
		expected_tokens.push_back(r);
	endfunction

	function automatic void buf_put(logic [7:0] c);
		if (lx_len < SLOTS) begin
			lx_buf[lx_len] = c;
			lx_len++;
		end else begin
			lx_buf[SLOTS-1] = c;
		end
	endfunction

	function automatic void put_name_char(logic [7:0] c);
		if (lx_kw && c >= "A" && c <= "Z")
			c = c + 8'd32;
		buf_put(c);
	endfunction

	function automatic void flush_token(logic [4:0] k);
		for (int i = 0; i < lx_len; i++)
			push_tok(k, 1'b1, lx_buf[i], E_ANGLE, 1'b0);
		lx_len = 0;
		push_tok(k, 1'b0, 8'h00, E_ANGLE, 1'b1);
	endfunction

	function automatic void flag_error(logic [2:0] e);
		lx_len = 0;
		lx_kw = 1'b0;
		lx_mode = S_IDLE;
		push_tok(K_ERROR, 1'b0, 8'h00, e, 1'b1);
	endfunction

	function automatic void begin_word(logic [7:0] c);
		lx_len = 0;
		if (digit_c(c)) begin
			lx_kw = 1'b0;
			buf_put(c);
			lx_mode = S_NUMBER;
		end else if (name_c(c)) begin
			put_name_char(c);
			lx_mode = S_NAME;
		end else begin
			lx_kw = 1'b0;
			lx_mode = S_IDLE;
			push_tok(K_RAW, 1'b0, c, E_ANGLE, 1'b1);
		end
	endfunction

	function automatic logic keyword_hit(int i);
		if (lx_len != int'(KW_LEN[i]))
			return 1'b0;
		for (int p = 0; p < lx_len; p++)
			if (lx_buf[p] != KW_STR[i][8*(lx_len-1-p) +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void close_name();
		lx_mode = S_IDLE;
		if (!lx_kw) begin
			flush_token(K_IDENT);
			return;
		end
		lx_kw = 1'b0;
		for (int i = 0; i < NKW; i++)
			if (keyword_hit(i)) begin
				flush_token(KW_KIND[i]);
				return;
			end
		flag_error(E_KEYWORD);
	endfunction

	function automatic void scan_from_idle(logic [7:0] c, logic eof);
		if (eof) begin
			push_tok(K_END, 1'b0, 8'h00, E_ANGLE, 1'b1);
			return;
		end
		if (c <= 8'h20) begin
			if (c == 8'h0a)
				bump_line();
			return;
		end
		case (c)
			"/": lx_mode = S_COM_OPEN;
			":": push_tok(K_COLON, 1'b0, 8'h00, E_ANGLE, 1'b1);
			";": push_tok(K_SEMI, 1'b0, 8'h00, E_ANGLE, 1'b1);
			"|": push_tok(K_BAR, 1'b0, 8'h00, E_ANGLE, 1'b1);
			"{", "=": push_tok(K_EQUALS, 1'b0, 8'h00, E_ANGLE, 1'b1);
			",": push_tok(K_COMMA, 1'b0, 8'h00, E_ANGLE, 1'b1);
			"^": push_tok(K_OUTPUT, 1'b0, 8'h00, E_ANGLE, 1'b1);
			"(": push_tok(K_LPAR, 1'b0, 8'h00, E_ANGLE, 1'b1);
			")": push_tok(K_RPAR, 1'b0, 8'h00, E_ANGLE, 1'b1);
			"<": begin
				lx_len = 0;
				lx_mode = S_ANGLE;
			end
			"\"", "'": begin
				lx_quote = c;
				lx_len = 0;
				buf_put(" ");
				lx_mode = S_QUOTE;
			end
			"%", "\\": lx_mode = S_DIRECTIVE;
			default: begin
				lx_kw = 1'b0;
				begin_word(c);
			end
		endcase
	endfunction

	function automatic void lex_byte(logic [7:0] c, logic eof);
		case (lx_mode)
			S_COM_OPEN: begin
				if (eof || c != "*") begin
					flag_error(E_COMMENT);
					if (!eof && c == 8'h0a)
						bump_line();
				end else begin
					lx_mode = S_COM_BODY;
				end
			end
			S_COM_BODY, S_COM_STAR: begin
				if (eof)
					flag_error(E_EOF_COM);
				else if (c == "/" && lx_mode == S_COM_STAR)
					lx_mode = S_IDLE;
				else if (c == "*")
					lx_mode = S_COM_STAR;
				else begin
					if (c == 8'h0a)
						bump_line();
					lx_mode = S_COM_BODY;
				end
			end
			S_ANGLE: begin
				if (!eof && c == ">") begin
					lx_mode = S_IDLE;
					flush_token(K_IDENT);
				end else if (eof || c == 8'h0a) begin
					flag_error(E_ANGLE);
					if (!eof)
						bump_line();
				end else begin
					buf_put(c);
				end
			end
			S_QUOTE: begin
				if (eof || c == 8'h0a) begin
					flag_error(E_QUOTE);
					if (!eof)
						bump_line();
				end else if (c == "\\") begin
					buf_put("\\");
					lx_mode = S_QUOTE_ESC;
				end else if (c == lx_quote) begin
					lx_mode = S_IDLE;
					flush_token(K_IDENT);
				end else begin
					buf_put(c);
				end
			end
			S_QUOTE_ESC: begin
				if (eof)
					flag_error(E_QUOTE);
				else begin
					buf_put(c);
					lx_mode = S_QUOTE;
				end
			end
			S_DIRECTIVE: begin
				lx_mode = S_IDLE;
				if (eof)
					push_tok(K_END, 1'b0, 8'h00, E_ANGLE, 1'b1);
				else
					case (c)
						"0": push_tok(K_TERM, 1'b0, 8'h00, E_ANGLE, 1'b1);
						"<": push_tok(K_LEFT, 1'b0, 8'h00, E_ANGLE, 1'b1);
						"2": push_tok(K_BINARY, 1'b0, 8'h00, E_ANGLE, 1'b1);
						">": push_tok(K_RIGHT, 1'b0, 8'h00, E_ANGLE, 1'b1);
						"%", "\\": push_tok(K_MARK, 1'b0, 8'h00, E_ANGLE, 1'b1);
						"=": push_tok(K_PREC, 1'b0, 8'h00, E_ANGLE, 1'b1);
						"{": push_tok(K_LCURL, 1'b0, 8'h00, E_ANGLE, 1'b1);
						default: begin
							lx_kw = 1'b1;
							begin_word(c);
						end
					endcase
			end
			S_NUMBER: begin
				if (!eof && digit_c(c))
					buf_put(c);
				else begin
					lx_mode = S_IDLE;
					flush_token(K_NUMBER);
					scan_from_idle(c, eof);
				end
			end
			S_NAME: begin
				if (!eof && (name_c(c) || digit_c(c)))
					put_name_char(c);
				else begin
					close_name();
					scan_from_idle(c, eof);
				end
			end
			default: begin
				lx_mode = S_IDLE;
				scan_from_idle(c, eof);
			end
		endcase
	endfunction

	// one byte transaction; prediction is made when it is accepted
	// valid stays up after acceptance so the next byte follows without a gap when no sender idling is set
	task automatic send_byte(logic [7:0] c, logic eof = 1'b0);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		end_of_input <= eof;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		lex_byte(c, eof);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic drain_tokens();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected result kind %0d char %h", $time,
						token_kind, text_char);
					fail_count++;
				end else begin
					token_res_t e;
					e = expected_tokens.pop_front();
					if (token_kind !== e.kind || is_text !== e.txt ||
							text_char !== e.ch || error_code !== e.code ||
							line_number !== e.line || last !== e.lst) begin
						$display("%0t: mismatch expected k%0d t%0d c%h e%0d l%0d x%0d",
							$time, e.kind, e.txt, e.ch, e.code, e.line, e.lst);
						$display("%0t:            actual k%0d t%0d c%h e%0d l%0d x%0d",
							$time, token_kind, is_text, text_char, error_code,
							line_number, last);
						fail_count++;
					end
				end
			end
			out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_punctuation();
		send_text(":;|={,^() \t");
		send_byte(8'h0a);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h80);
	endtask

	task automatic test_directives();
		send_text("%0%<\\2%>%%\\\\%=%{%!%5%\n");
		send_text("%PREC %Token %attributes %attribute %bogus\\union ");
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_tokens_and_errors();
		send_text("<abc>'a\\'b\"x\"12345 name_9.$ ");
		send_text("/* c\n* */ /x/ ");
		send_text("<bad\n\"bad\n");
		send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ ");
		send_text("'");
		send_byte(8'h00, 1'b1);
		send_text("/*");
		send_byte(8'h00, 1'b1);
	endtask

	task automatic random_bytes(int n);
		string frags[] = '{"%token ", "%left ", "%prec ", "%start ", "%type ",
			"%union ", "%nonassoc ", "%right ", "%binary ", "%term ", "expr: ",
			"a | b ;", "<int>", "'x'", "\"s\\n\"", "123 ", "/* z */", "\n",
			"(x,y)", "%%", "%xyz "};
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 75) begin
				string f;
				f = frags[$urandom_range(frags.size()-1)];
				send_text(f);
				sent += f.len();
			end else begin
				send_byte(8'($urandom_range(255)), $urandom_range(30) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		lx_mode = S_IDLE; lx_len = 0; lx_kw = 1'b0; lx_quote = 8'h00;
		lx_line = 16'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		out_ready <= 1'b1;
		@(posedge clk);
		// no idling
		test_punctuation();
		// sender idle most of the time
		send_idle_pct = 82;
		test_directives();
		// receiver stalling most of the time
		send_idle_pct = 0; recv_stall_pct = 82;
		test_tokens_and_errors();
		drain_tokens();
		// both sides idling now and then
		send_idle_pct = 28; recv_stall_pct = 28;
		random_bytes(20);
		send_byte(8'h00, 1'b1);
		drain_tokens();
		recv_stall_pct = 0;
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// File: files.f
+incdir+src
src/gfl_pkg.sv
src/gfl_ram.sv
src/gfl_front.sv
src/gfl_cmdq.sv
src/gfl_back.sv
src/grammar_file_lexer.sv
src/gfl_checker.sv
sim/grammar_file_lexer_tb.sv
